### rtl/core/rbd_pkg.sv
// Shared types, codes and defaults for the ring buffer deque.
package rbd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 5;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [FILL_W-1:0]   t_fill;

    localparam t_func FUNC_PUSH_BACK  = 2'd0;
    localparam t_func FUNC_PUSH_FRONT = 2'd1;
    localparam t_func FUNC_POP_FRONT  = 2'd2;
    localparam t_func FUNC_POP_BACK   = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        t_func func;
        t_word push_value;
    } t_in;

    typedef struct packed {
        t_word   pop_value;
        t_status status;
        logic    is_empty;
        t_fill   fill_count;
    } t_out;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### rtl/core/ring_buffer_deque_core.sv
// Ring buffer deque top level: pointer control, store access and result stage.
//
//   channel  direction  valid        stall         payload
//   in       input      i_in_valid   o_in_stall    i_in_data  (rbd_pkg::t_in)
//   out      output     o_out_valid  i_out_stall   o_out_data (rbd_pkg::t_out)
//
// One request per cycle while o_in_stall is low; its result passes through the read stage and then the result register.
// The store has one port, so a request writes or reads at most one entry.
// Reset clears head, count and the valid bits of both stages; the store is not cleared.
// An output stall holds the result register, then the read stage, then input.
module ring_buffer_deque_core #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rbd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rbd_pkg::t_out o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    logic            r_s1_valid;
    rbd_pkg::t_status r_s1_status;
    logic [CW-1:0]   r_s1_count;
    logic            r_s1_pop;

    logic          r_out_valid;
    rbd_pkg::t_out r_out;

    logic              w_acc, w_push, w_full, w_empty, w_s1_move;
    logic [SW-1:0]     w_head_ext, w_cnt_ext, w_back_sum, w_last_sum, w_next_sum;
    logic [AW-1:0]     w_back_pos, w_last_pos, w_next_pos, w_prev_pos, w_addr;
    rbd_pkg::t_mem_ctl w_ctl;
    rbd_pkg::t_status  w_status;
    rbd_pkg::t_word    w_rd_data;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_move;
    assign w_acc      = i_in_valid && !o_in_stall;

    assign w_push  = (i_in_data.func == rbd_pkg::FUNC_PUSH_BACK) ||
                     (i_in_data.func == rbd_pkg::FUNC_PUSH_FRONT);
    assign w_full  = (r_count == DEPTH_C);
    assign w_empty = (r_count == '0);

    assign w_head_ext = SW'(r_head);
    assign w_cnt_ext  = SW'(r_count);
    assign w_back_sum = w_head_ext + w_cnt_ext;
    assign w_last_sum = w_back_sum - SW'(1);
    assign w_next_sum = w_head_ext + SW'(1);

    assign w_back_pos = (w_back_sum >= DEPTH_S) ? AW'(w_back_sum - DEPTH_S) : AW'(w_back_sum);
    assign w_last_pos = (w_last_sum >= DEPTH_S) ? AW'(w_last_sum - DEPTH_S) : AW'(w_last_sum);
    assign w_next_pos = (w_next_sum >= DEPTH_S) ? AW'(w_next_sum - DEPTH_S) : AW'(w_next_sum);
    assign w_prev_pos = (r_head == '0) ? LAST_A : r_head - AW'(1);

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        w_addr      = w_back_pos;
        w_ctl       = '0;
        w_status    = rbd_pkg::ST_OK;
        unique case (i_in_data.func)
            rbd_pkg::FUNC_PUSH_BACK: begin
                if (w_full) begin
                    w_status = rbd_pkg::ST_FULL;
                end else begin
                    w_ctl.wr_en = w_acc;
                    n_count     = r_count + CW'(1);
                end
            end
            rbd_pkg::FUNC_PUSH_FRONT: begin
                w_addr = w_prev_pos;
                if (w_full) begin
                    w_status = rbd_pkg::ST_FULL;
                end else begin
                    w_ctl.wr_en = w_acc;
                    n_head      = w_prev_pos;
                    n_count     = r_count + CW'(1);
                end
            end
            rbd_pkg::FUNC_POP_FRONT: begin
                w_addr = r_head;
                if (w_empty) begin
                    w_status = rbd_pkg::ST_EMPTY;
                end else begin
                    w_ctl.rd_en = w_acc;
                    n_head      = w_next_pos;
                    n_count     = r_count - CW'(1);
                end
            end
            rbd_pkg::FUNC_POP_BACK: begin
                w_addr = w_last_pos;
                if (w_empty) begin
                    w_status = rbd_pkg::ST_EMPTY;
                end else begin
                    w_ctl.rd_en = w_acc;
                    n_count     = r_count - CW'(1);
                end
            end
            default: begin
                w_status = rbd_pkg::ST_OK;
            end
        endcase
    end

    rbd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_addr    (w_addr),
        .i_wr_data (i_in_data.push_value),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (w_acc) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_status <= w_status;
            r_s1_count  <= n_count;
            r_s1_pop    <= w_ctl.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out.pop_value  <= r_s1_pop ? w_rd_data : '0;
            r_out.status     <= r_s1_status;
            r_out.is_empty   <= (r_s1_count == '0);
            r_out.fill_count <= rbd_pkg::t_fill'(r_s1_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with an empty pipeline");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_push && !w_full) |=> (r_count == CW'($past(r_count) + CW'(1))))
        else $error("accepted push did not advance count");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rd_en |-> !w_empty)
        else $error("store read issued on empty queue");

    a_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != rbd_pkg::ST_OK) |-> (r_out.pop_value == '0))
        else $error("failed beat carries a nonzero word");

endmodule

### rtl/core/rbd_store.sv
// Entry store: single-port synchronous memory with registered read data.
module rbd_store #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  rbd_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  rbd_pkg::t_word    i_wr_data,
    output rbd_pkg::t_word    o_rd_data
);

    rbd_pkg::t_word r_mem [DEPTH];
    rbd_pkg::t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/tb_ring_buffer_deque_core.sv
// Testbench for ring_buffer_deque_core: directed table and random requests checked by a predictor.
module tb_ring_buffer_deque_core;

    import rbd_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int RANDOM_BEATS = 1850;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_func func;
        t_word value;
        logic  typed;
        t_out  want;
    } t_row;

    localparam t_out NO_WANT = '0;

    localparam int NUM_ROWS = 26;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
        '{FUNC_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
        '{FUNC_PUSH_BACK,  32'h0000_0000, 1'b1, '{32'h0, ST_OK,    1'b0, 5'd1}},
        '{FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,    1'b0, 5'd2}},
        '{FUNC_POP_BACK,   32'h1234_5678, 1'b0, NO_WANT},
        '{FUNC_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'h8000_0001, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'h7FFF_FFFE, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'hA5A5_5A5A, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'h5A5A_A5A5, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'h0000_0000, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'h0000_0001, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'h8000_0000, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'hCAFE_F00D, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'h3333_CCCC, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'hCCCC_3333, 1'b0, NO_WANT},
        '{FUNC_PUSH_FRONT, 32'h0000_FFFF, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'hFFFF_0000, 1'b0, NO_WANT},
        '{FUNC_PUSH_BACK,  32'h1111_1111, 1'b1, '{32'h0, ST_FULL,  1'b0, 5'd16}},
        '{FUNC_PUSH_FRONT, 32'h2222_2222, 1'b1, '{32'h0, ST_FULL,  1'b0, 5'd16}},
        '{FUNC_POP_BACK,   32'h0000_0000, 1'b0, NO_WANT},
        '{FUNC_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT}
    };

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic hold_off  = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    t_word stored_words [DEPTH];
    int    front_slot = 0;
    int    held_count = 0;
    t_out  pending_results [$];

    int mismatches      = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int feed_calm_left  = 0;
    int drain_calm_left = 0;
    int drain_stall_left = 0;
    int roll;
    logic stall_pick;

    ring_buffer_deque_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_out deque_predict(t_in beat);
        t_out              res;
        logic [SLOT_W-1:0] slot;
        res = '0;
        res.status = ST_OK;
        if (beat.func == FUNC_PUSH_BACK || beat.func == FUNC_PUSH_FRONT) begin
            if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                if (beat.func == FUNC_PUSH_BACK) begin
                    slot = SLOT_W'((front_slot + held_count) % DEPTH);
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    slot = SLOT_W'(front_slot);
                end
                stored_words[slot] = beat.push_value;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            if (beat.func == FUNC_POP_FRONT) begin
                slot = SLOT_W'(front_slot);
                front_slot = (front_slot + 1) % DEPTH;
            end else begin
                slot = SLOT_W'((front_slot + held_count - 1) % DEPTH);
            end
            res.pop_value = stored_words[slot];
            held_count--;
        end
        res.is_empty = (held_count == 0);
        res.fill_count = t_fill'(held_count);
        return res;
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_func pick_func(int push_pct);
        if ($urandom_range(99) < push_pct) begin
            return $urandom_range(1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
        end
        return $urandom_range(1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
    endfunction

    task automatic send_beat(t_in beat);
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap();
        int gap;
        int gap_roll;
        gap = 0;
        if (feed_calm_left > 0) begin
            feed_calm_left--;
        end else begin
            gap_roll = $urandom_range(99);
            if (gap_roll < 2) feed_calm_left = $urandom_range(40, 150);
            else if (gap_roll < 30) gap = $urandom_range(1, 3);
            else if (gap_roll < 34) gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (pending_results.size() == 0) begin
            $error("unexpected result beat: pop_value %h status %0d", got.pop_value, got.status);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            if (got.pop_value !== want.pop_value) begin
                $error("pop_value expected %h actual %h", want.pop_value, got.pop_value);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty expected %0b actual %0b", want.is_empty, got.is_empty);
                mismatches++;
            end
            if (got.fill_count !== want.fill_count) begin
                $error("fill_count expected %0d actual %0d", want.fill_count, got.fill_count);
                mismatches++;
            end
        end
        results_checked++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) check_result(out_data);
            stall_pick = 1'b0;
            if (drain_stall_left > 0) begin
                drain_stall_left--;
                stall_pick = 1'b1;
            end else if (drain_calm_left > 0) begin
                drain_calm_left--;
            end else begin
                roll = $urandom_range(99);
                if (roll < 2) begin
                    drain_calm_left = $urandom_range(40, 150);
                end else if (roll < 27) begin
                    stall_pick = 1'b1;
                    drain_stall_left = $urandom_range(0, 2);
                end else if (roll < 31) begin
                    stall_pick = 1'b1;
                    drain_stall_left = $urandom_range(7, 24);
                end
            end
            out_stall <= stall_pick || hold_off;
        end
    end

    initial begin
        while (results_checked < HOLD_AFTER) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        t_in  beat;
        t_out want;
        int   push_pct;
        int   bias_left;
        push_pct  = 50;
        bias_left = 0;
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            beat.func       = DIRECTED_ROWS[i].func;
            beat.push_value = DIRECTED_ROWS[i].value;
            send_beat(beat);
            want = deque_predict(beat);
            if (DIRECTED_ROWS[i].typed) want = DIRECTED_ROWS[i].want;
            pending_results.push_back(want);
            idle_gap();
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (bias_left == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                bias_left = $urandom_range(24, 80);
            end
            bias_left--;
            beat.func       = pick_func(push_pct);
            beat.push_value = pick_word();
            send_beat(beat);
            pending_results.push_back(deque_predict(beat));
            idle_gap();
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/rbd_pkg.sv
rtl/core/rbd_store.sv
rtl/core/ring_buffer_deque_core.sv
tb/tb_ring_buffer_deque_core.sv
